// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the simplex noise block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SN_ASSERT_IMP(lbl, ante, cons, msg)
`define SN_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/snoise_pkg.sv
// Types, fixed-point constants and gradient table of the simplex noise block.
// No dependencies.
package snoise_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned NLANE      = 4;
  localparam int unsigned NLEVEL     = 3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVAL2 = 2'd1,
    OP_EVAL3 = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_OFF_X = 2'd0,
    CFG_OFF_Y = 2'd1,
    CFG_OFF_Z = 2'd2
  } cfg_idx_t;

  localparam logic [30:0] Q30_ONE   = 31'd1073741824;
  localparam logic [29:0] SKEW2_C   = 30'd393016785;
  localparam logic [29:0] SKEW3_C   = 30'd357913941;
  localparam logic [27:0] UNSKEW2_C = 28'd226908346;
  localparam logic [27:0] UNSKEW3_C = 28'd178956971;
  localparam logic [29:0] RAD2_C    = 30'd536870912;
  localparam logic [29:0] RAD3_C    = 30'd644245094;

  localparam logic [29:0] KOFF2 [NLANE] = '{30'd0, 30'd226908346, 30'd453816692, 30'd0};
  localparam logic [29:0] KOFF3 [NLANE] =
    '{30'd0, 30'd178956971, 30'd357913942, 30'd536870913};

  localparam logic [1:0] GC_POS = 2'b01;
  localparam logic [1:0] GC_NEG = 2'b11;

  localparam logic [5:0] GRAD_TAB [12] = '{
    6'b01_01_00, 6'b11_01_00, 6'b01_11_00, 6'b11_11_00,
    6'b01_00_01, 6'b11_00_01, 6'b01_00_11, 6'b11_00_11,
    6'b00_01_01, 6'b00_11_01, 6'b00_01_11, 6'b00_11_11};

  typedef struct packed {
    logic               is3d;
    logic signed [31:0] gain;
    logic signed [63:0] acc;
    logic               sweep;
  } side_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [30:0] f;
  } cell_t;

  function automatic logic [5:0] grad_code(input logic [7:0] h);
    logic [15:0] p;
    logic [7:0]  q12;
    logic [7:0]  r;
    p   = 16'(h) * 16'd171;
    q12 = 8'(p[15:11]) * 8'd12;
    r   = h - q12;
    return GRAD_TAB[r[3:0]];
  endfunction

endpackage

// File: rtl/simplex_noise_2d_3d.sv
// Simplex noise evaluator, 2D and 3D, one point per cycle through an 18-stage pipeline.
// The rate holds while out_ready is high; each evaluation passes stages 1 to 18 to out_valid.
// A load request waits until the first 12 stages (up to the last table read) hold no request.
// Synchronous active-low reset clears the valid bits and the offsets; the table is not cleared.
// Uses snoise_pkg and assert_macros.svh.
`include "assert_macros.svh"
module simplex_noise_2d_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_table_index,
  input  logic [7:0]          in_table_value,
  input  logic signed [47:0]  in_x_coord,
  input  logic signed [47:0]  in_y_coord,
  input  logic signed [47:0]  in_z_coord,
  input  logic signed [31:0]  in_gain,
  input  logic signed [63:0]  in_acc_in,
  input  logic                in_sweep_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_noise_value,
  output logic signed [63:0]  out_acc_out,
  output logic                out_sweep_end
);
  import snoise_pkg::*;

  localparam int NSTG = 18;

  function automatic cell_t cell_f(input logic signed [51:0] u);
    logic [FRAC_BITS-1:0] fr;
    cell_t c;
    fr    = u[FRAC_BITS-1:0];
    c.idx = u[FRAC_BITS+7:FRAC_BITS];
    c.f   = 31'(fr) << (30 - FRAC_BITS);
    if (fr == '0 && (u[51] || u == '0)) begin
      c.idx = c.idx - 8'd1;
      c.f   = Q30_ONE;
    end
    return c;
  endfunction

  function automatic logic signed [33:0] gsel(input logic [1:0] g,
                                              input logic signed [31:0] v);
    unique case (g)
      GC_POS:  return 34'(v);
      GC_NEG:  return -34'(v);
      default: return '0;
    endcase
  endfunction

  logic [23:0] off_r [3];
  logic [NSTG:1] v_r;
  logic [NSTG:1] en;
  side_t side_r [1:NSTG];

  logic load_ok, load_acc, eval_acc, is_eval;

  logic signed [48:0] xyz_r   [1:4][3];
  logic signed [50:0] ssum_r;
  logic signed [61:0] phi_r;
  logic signed [51:0] plo_r;
  logic signed [51:0] s_r;
  logic [7:0]         idx_r   [5:11][3];
  logic [30:0]        fq_r    [5:7][3];
  logic [31:0]        fsum_r;
  logic [59:0]        tprod_r;
  logic signed [32:0] d0_r [3];
  logic [2:0]         ofs_r   [9:11][NLANE];
  logic signed [31:0] crd_r   [9:12][NLANE][3];
  logic               le_r    [9:12][NLANE];
  logic [33:0]        sq_r    [NLANE][3];
  logic [29:0]        t1_r    [NLANE];
  logic [29:0]        t2_r    [NLANE];
  logic [29:0]        t4_r    [NLANE];
  logic signed [33:0] dot_r   [NLANE];
  logic signed [34:0] contrib_r [NLANE];
  logic signed [36:0] sum_r;
  logic signed [31:0] noise_r [16:18];
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_out_r;

  logic [7:0] taddr [NLEVEL][NLANE];
  logic [7:0] tdata [NLEVEL][NLANE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OFF_X: off_r[0] <= cfg_data;
        CFG_OFF_Y: off_r[1] <= cfg_data;
        CFG_OFF_Z: off_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign load_ok  = (v_r[12:1] == '0);
  assign in_ready = (in_opcode == OP_LOAD) ? load_ok : en[1];
  assign is_eval  = (in_opcode == OP_EVAL2) || (in_opcode == OP_EVAL3);
  assign load_acc = in_valid && in_ready && (in_opcode == OP_LOAD);
  assign eval_acc = in_valid && in_ready && is_eval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= eval_acc;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1].is3d  <= (in_opcode == OP_EVAL3);
      side_r[1].gain  <= in_gain;
      side_r[1].acc   <= in_acc_in;
      side_r[1].sweep <= in_sweep_last;
      xyz_r[1][0] <= 49'(in_x_coord) + $signed({25'd0, off_r[0]});
      xyz_r[1][1] <= 49'(in_y_coord) + $signed({25'd0, off_r[1]});
      xyz_r[1][2] <= (in_opcode == OP_EVAL3) ?
                     49'(in_z_coord) + $signed({25'd0, off_r[2]}) : '0;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) xyz_r[k] <= xyz_r[k-1];
    end
  end

  // Skew factor: exact floor of sum * F / 2^30 from two partial products.
  logic [29:0] skew_c;
  assign skew_c = side_r[2].is3d ? SKEW3_C : SKEW2_C;

  logic signed [81:0] full_nxt;
  assign full_nxt = (82'(phi_r) <<< 20) + 82'(plo_r);

  cell_t cell_nxt [3];
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      cell_nxt[d] = cell_f(52'(xyz_r[4][d]) + s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) ssum_r <= 51'(xyz_r[1][0]) + 51'(xyz_r[1][1]) + 51'(xyz_r[1][2]);
    if (en[3]) begin
      phi_r <= $signed(ssum_r[50:20]) * $signed({1'b0, skew_c});
      plo_r <= $signed({1'b0, ssum_r[19:0]}) * $signed({1'b0, skew_c});
    end
    if (en[4]) s_r <= full_nxt[81:30];
    if (en[5]) begin
      for (int d = 0; d < 3; d++) begin
        idx_r[5][d] <= cell_nxt[d].idx;
        fq_r[5][d]  <= cell_nxt[d].f;
      end
    end
    for (int k = 6; k <= 11; k++) begin
      if (en[k]) idx_r[k] <= idx_r[k-1];
    end
    for (int k = 6; k <= 7; k++) begin
      if (en[k]) fq_r[k] <= fq_r[k-1];
    end
    if (en[6]) begin
      fsum_r <= 32'(fq_r[5][0]) + 32'(fq_r[5][1]) +
                (side_r[5].is3d ? 32'(fq_r[5][2]) : 32'd0);
    end
    if (en[7]) begin
      tprod_r <= fsum_r * (side_r[6].is3d ? UNSKEW3_C : UNSKEW2_C);
    end
    if (en[8]) begin
      for (int d = 0; d < 3; d++) begin
        d0_r[d] <= (d == 2 && !side_r[7].is3d) ? 33'sd0 :
                   $signed({2'b0, fq_r[7][d]}) - $signed({3'b0, tprod_r[59:30]});
      end
    end
  end

  // Corner order and per-lane corner coordinates.
  logic [2:0]         ofs_nxt [NLANE];
  logic signed [31:0] crd_nxt [NLANE][3];
  logic signed [33:0] ctmp;
  always_comb begin
    ofs_nxt[0] = 3'b000;
    ofs_nxt[3] = 3'b111;
    if (side_r[8].is3d) begin
      if (d0_r[0] >= d0_r[1]) begin
        if (d0_r[1] >= d0_r[2]) begin
          ofs_nxt[1] = 3'b100; ofs_nxt[2] = 3'b110;
        end else if (d0_r[0] >= d0_r[2]) begin
          ofs_nxt[1] = 3'b100; ofs_nxt[2] = 3'b101;
        end else begin
          ofs_nxt[1] = 3'b001; ofs_nxt[2] = 3'b101;
        end
      end else begin
        if (d0_r[1] < d0_r[2]) begin
          ofs_nxt[1] = 3'b001; ofs_nxt[2] = 3'b011;
        end else if (d0_r[0] < d0_r[2]) begin
          ofs_nxt[1] = 3'b010; ofs_nxt[2] = 3'b011;
        end else begin
          ofs_nxt[1] = 3'b010; ofs_nxt[2] = 3'b110;
        end
      end
    end else begin
      ofs_nxt[1] = (d0_r[0] > d0_r[1]) ? 3'b100 : 3'b010;
      ofs_nxt[2] = 3'b110;
    end
    for (int l = 0; l < NLANE; l++) begin
      for (int d = 0; d < 3; d++) begin
        ctmp = 34'(d0_r[d]) - (ofs_nxt[l][2-d] ? $signed({3'b0, Q30_ONE}) : 34'sd0) +
               $signed({4'b0, side_r[8].is3d ? KOFF3[l] : KOFF2[l]});
        crd_nxt[l][d] = ctmp[31:0];
      end
      if (!side_r[8].is3d) crd_nxt[l][2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int l = 0; l < NLANE; l++) begin
        ofs_r[9][l] <= ofs_nxt[l];
        crd_r[9][l] <= crd_nxt[l];
        le_r[9][l]  <= side_r[8].is3d || (l != NLANE - 1);
      end
    end
    for (int k = 10; k <= 11; k++) begin
      if (en[k]) ofs_r[k] <= ofs_r[k-1];
    end
    for (int k = 10; k <= 12; k++) begin
      if (en[k]) begin
        crd_r[k] <= crd_r[k-1];
        le_r[k]  <= le_r[k-1];
      end
    end
  end

  // Hash chain: one replicated table per lane and level, one read port each.
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      taddr[0][l] = idx_r[9][2] + 8'(ofs_r[9][l][0]);
      taddr[1][l] = idx_r[10][1] + 8'(ofs_r[10][l][1]) +
                    (side_r[10].is3d ? tdata[0][l] : 8'd0);
      taddr[2][l] = idx_r[11][0] + 8'(ofs_r[11][l][2]) + tdata[1][l];
    end
  end

  for (genvar lv = 0; lv < NLEVEL; lv++) begin : g_lvl
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic [7:0] tbl_mem [TABLE_SIZE];
      logic [7:0] rd_r;
      always_ff @(posedge clk) begin
        if (load_acc) tbl_mem[in_table_index] <= in_table_value;
        if (en[10+lv]) rd_r <= tbl_mem[taddr[lv][l]];
      end
      assign tdata[lv][l] = rd_r;
    end
  end

  // Corner attenuation and gradient dot product.
  logic signed [36:0] r_nxt  [NLANE];
  logic [59:0]        t2_nxt [NLANE];
  logic [59:0]        t4_nxt [NLANE];
  logic [5:0]         gc     [NLANE];
  logic signed [64:0] cp_nxt [NLANE];
  logic [33:0]        sq_nxt [NLANE][3];
  logic signed [63:0] sqp;
  logic [29:0]        lim;
  assign lim = side_r[10].is3d ? RAD3_C : RAD2_C;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      for (int d = 0; d < 3; d++) begin
        sqp          = crd_r[9][l][d] * crd_r[9][l][d];
        sq_nxt[l][d] = sqp[63:30];
      end
      r_nxt[l]  = $signed({7'd0, lim}) - $signed({3'd0, sq_r[l][0]}) -
                  $signed({3'd0, sq_r[l][1]}) - $signed({3'd0, sq_r[l][2]});
      t2_nxt[l] = t1_r[l] * t1_r[l];
      t4_nxt[l] = t2_r[l] * t2_r[l];
      gc[l]     = grad_code(tdata[2][l]);
      cp_nxt[l] = $signed({1'b0, t4_r[l]}) * dot_r[l];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANE; l++) begin
      if (en[10]) begin
        for (int d = 0; d < 3; d++) begin
          sq_r[l][d] <= sq_nxt[l][d];
        end
      end
      if (en[11]) t1_r[l] <= r_nxt[l][36] ? 30'd0 : r_nxt[l][29:0];
      if (en[12]) t2_r[l] <= t2_nxt[l][59:30];
      if (en[13]) begin
        t4_r[l]  <= le_r[12][l] ? t4_nxt[l][59:30] : 30'd0;
        dot_r[l] <= gsel(gc[l][5:4], crd_r[12][l][0]) +
                    gsel(gc[l][3:2], crd_r[12][l][1]) +
                    gsel(gc[l][1:0], crd_r[12][l][2]);
      end
      if (en[14]) contrib_r[l] <= cp_nxt[l][64:30];
    end
  end

  // Scale, saturate, then gain and saturating accumulate.
  logic signed [43:0] sc_nxt;
  logic signed [63:0] pshift;
  logic signed [64:0] asum;
  always_comb begin
    sc_nxt = side_r[15].is3d ? (44'(sum_r) <<< 5) :
             (44'(sum_r) <<< 6) + (44'(sum_r) <<< 2) + (44'(sum_r) <<< 1);
    pshift = prod_r >>> FRAC_BITS;
    asum   = 65'(side_r[17].acc) + 65'(pshift);
  end

  always_ff @(posedge clk) begin
    if (en[15]) begin
      sum_r <= 37'(contrib_r[0]) + 37'(contrib_r[1]) +
               37'(contrib_r[2]) + 37'(contrib_r[3]);
    end
    if (en[16]) begin
      if (sc_nxt > 44'sd2147483647) noise_r[16] <= 32'sh7FFFFFFF;
      else if (sc_nxt < -44'sd2147483648) noise_r[16] <= 32'sh80000000;
      else noise_r[16] <= sc_nxt[31:0];
    end
    if (en[17]) begin
      prod_r      <= noise_r[16] * side_r[16].gain;
      noise_r[17] <= noise_r[16];
    end
    if (en[18]) begin
      noise_r[18] <= noise_r[17];
      if (asum[64] != asum[63]) begin
        acc_out_r <= asum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
      end else begin
        acc_out_r <= asum[63:0];
      end
    end
  end

  assign out_valid       = v_r[NSTG];
  assign out_noise_value = noise_r[18];
  assign out_acc_out     = acc_out_r;
  assign out_sweep_end   = side_r[NSTG].sweep;

  `SN_ASSERT_IMP(a_load_drained, load_acc, v_r[12:1] == '0, "load taken with table reads pending")
  `SN_ASSERT_NXT(a_eval_enters, eval_acc, v_r[1], "evaluate request lost at pipeline entry")
  `SN_ASSERT_IMP(a_2d_lane_off, v_r[14] && !side_r[14].is3d, contrib_r[3] == '0, "2D extra corner used")

endmodule

// File: verif/tb.sv
// Self-checking testbench for simplex_noise_2d_3d: loads the permutation table, then runs
// directed and random 2D/3D evaluate requests under several offset settings and checks results.
// Depends on snoise_pkg and the RTL of simplex_noise_2d_3d.
`timescale 1ns / 1ps
module tb;
  import snoise_pkg::*;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam longint ONE_Q30 = longint'(Q30_ONE);
  localparam longint SK2 = longint'(SKEW2_C);
  localparam longint SK3 = longint'(SKEW3_C);
  localparam longint UN2 = longint'(UNSKEW2_C);
  localparam longint UN3 = longint'(UNSKEW3_C);
  localparam longint LIM2 = longint'(RAD2_C);
  localparam longint LIM3 = longint'(RAD3_C);
  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         tidx;
    logic [7:0]         tval;
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
    logic signed [31:0] gain;
    logic signed [63:0] acc;
    logic               sweep;
  } point_req_t;

  typedef struct {
    logic signed [31:0] noise;
    logic signed [63:0] acc;
    logic               sweep;
  } point_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [7:0] in_table_index = '0;
  logic [7:0] in_table_value = '0;
  logic signed [47:0] in_x_coord = '0;
  logic signed [47:0] in_y_coord = '0;
  logic signed [47:0] in_z_coord = '0;
  logic signed [31:0] in_gain = '0;
  logic signed [63:0] in_acc_in = '0;
  logic in_sweep_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_noise_value;
  logic signed [63:0] out_acc_out;
  logic out_sweep_end;

  simplex_noise_2d_3d u_dut (.*);

  always #10 clk = ~clk;

  point_req_t pending_reqs[$];
  point_res_t expected_points[$];
  logic [7:0] perm_tbl[256];
  logic [23:0] off_x, off_y, off_z;
  int gx[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  int gy[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
  int gz[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
  int queued_cnt = 0, sent_cnt = 0, err_cnt = 0, checked_cnt = 0;
  int n_eval2 = 0, n_eval3 = 0, n_load = 0, n_cfg = 0;

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint skew_mul(longint a, longint c);
    logic signed [127:0] pa, pc;
    pa = a;
    pc = c;
    return longint'((pa * pc) >>> 30);
  endfunction

  function automatic void cell_of(input longint u, output logic [7:0] idx, output longint f);
    longint i, fr;
    i = u >>> FRAC;
    fr = u & ((longint'(1) << FRAC) - 1);
    if (fr == 0 && u <= 0) begin
      i = i - 1;
      fr = longint'(1) << FRAC;
    end
    idx = i[7:0];
    f = fr << (30 - FRAC);
  endfunction

  function automatic logic [7:0] pt(logic [7:0] a);
    return perm_tbl[a];
  endfunction

  function automatic longint corner_part(longint lim, longint x, longint y, longint z,
                                         logic [7:0] h);
    longint t;
    int g;
    g = h % 12;
    t = lim - mulq(x, x) - mulq(y, y) - mulq(z, z);
    if (t < 0) return 0;
    t = mulq(t, t);
    t = mulq(t, t);
    return mulq(t, gx[g] * x + gy[g] * y + gz[g] * z);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint noise_2d(longint xin, longint yin);
    longint s, fx, fy, t, x0, y0, sum;
    logic [7:0] ii, jj, i1, j1;
    s = skew_mul(xin + yin, SK2);
    cell_of(xin + s, ii, fx);
    cell_of(yin + s, jj, fy);
    t = mulq(fx + fy, UN2);
    x0 = fx - t;
    y0 = fy - t;
    i1 = (x0 > y0) ? 8'd1 : 8'd0;
    j1 = 8'd1 - i1;
    sum = corner_part(LIM2, x0, y0, 0, pt(ii + pt(jj)));
    sum += corner_part(LIM2, x0 - i1 * ONE_Q30 + UN2, y0 - j1 * ONE_Q30 + UN2, 0,
                       pt(ii + i1 + pt(jj + j1)));
    sum += corner_part(LIM2, x0 - ONE_Q30 + 2 * UN2, y0 - ONE_Q30 + 2 * UN2, 0,
                       pt(ii + 8'd1 + pt(jj + 8'd1)));
    return clip32(70 * sum);
  endfunction

  function automatic longint noise_3d(longint xin, longint yin, longint zin);
    longint s, fx, fy, fz, t, x0, y0, z0, sum;
    logic [7:0] ii, jj, kk, i1, j1, k1, i2, j2, k2;
    s = skew_mul(xin + yin + zin, SK3);
    cell_of(xin + s, ii, fx);
    cell_of(yin + s, jj, fy);
    cell_of(zin + s, kk, fz);
    t = mulq(fx + fy + fz, UN3);
    x0 = fx - t;
    y0 = fy - t;
    z0 = fz - t;
    if (x0 >= y0) begin
      if (y0 >= z0) {i1, j1, k1, i2, j2, k2} = {8'd1, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0};
      else if (x0 >= z0) {i1, j1, k1, i2, j2, k2} = {8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1};
      else {i1, j1, k1, i2, j2, k2} = {8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd1};
    end else begin
      if (y0 < z0) {i1, j1, k1, i2, j2, k2} = {8'd0, 8'd0, 8'd1, 8'd0, 8'd1, 8'd1};
      else if (x0 < z0) {i1, j1, k1, i2, j2, k2} = {8'd0, 8'd1, 8'd0, 8'd0, 8'd1, 8'd1};
      else {i1, j1, k1, i2, j2, k2} = {8'd0, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0};
    end
    sum = corner_part(LIM3, x0, y0, z0, pt(ii + pt(jj + pt(kk))));
    sum += corner_part(LIM3, x0 - i1 * ONE_Q30 + UN3, y0 - j1 * ONE_Q30 + UN3,
                       z0 - k1 * ONE_Q30 + UN3, pt(ii + i1 + pt(jj + j1 + pt(kk + k1))));
    sum += corner_part(LIM3, x0 - i2 * ONE_Q30 + 2 * UN3, y0 - j2 * ONE_Q30 + 2 * UN3,
                       z0 - k2 * ONE_Q30 + 2 * UN3, pt(ii + i2 + pt(jj + j2 + pt(kk + k2))));
    sum += corner_part(LIM3, x0 - ONE_Q30 + 3 * UN3, y0 - ONE_Q30 + 3 * UN3,
                       z0 - ONE_Q30 + 3 * UN3, pt(ii + 8'd1 + pt(jj + 8'd1 + pt(kk + 8'd1))));
    return clip32(32 * sum);
  endfunction

  // Updates the table or queues the expected point for one accepted request; an OP_NONE request changes neither.
  function automatic void apply_request(point_req_t r);
    longint xin, yin, zin, nz, prod, acc;
    point_res_t e;
    if (r.op == OP_LOAD) begin
      perm_tbl[r.tidx] = r.tval;
      n_load++;
      return;
    end
    if (r.op == OP_NONE) return;
    xin = longint'(r.x) + longint'({40'd0, off_x});
    yin = longint'(r.y) + longint'({40'd0, off_y});
    zin = longint'(r.z) + longint'({40'd0, off_z});
    if (r.op == OP_EVAL2) begin
      nz = noise_2d(xin, yin);
      n_eval2++;
    end else begin
      nz = noise_3d(xin, yin, zin);
      n_eval3++;
    end
    prod = (nz * longint'(r.gain)) >>> FRAC;
    acc = r.acc;
    if (prod > 0 && acc > S64_MAX - prod) acc = S64_MAX;
    else if (prod < 0 && acc < S64_MIN - prod) acc = S64_MIN;
    else acc = acc + prod;
    e.noise = nz[31:0];
    e.acc = acc;
    e.sweep = r.sweep;
    expected_points.push_back(e);
  endfunction

  function automatic void queue_point(logic [1:0] op, logic signed [47:0] x,
                                      logic signed [47:0] y, logic signed [47:0] z,
                                      logic signed [31:0] gain, logic signed [63:0] acc,
                                      logic sw);
    point_req_t r;
    r.op = op;
    r.tidx = 8'($urandom);
    r.tval = 8'($urandom);
    r.x = x;
    r.y = y;
    r.z = z;
    r.gain = gain;
    r.acc = acc;
    r.sweep = sw;
    pending_reqs.push_back(r);
    queued_cnt++;
  endfunction

  function automatic logic signed [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic signed [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [47:0] rnd_coord();
    if ($urandom_range(0, 9) == 0) return rnd48();
    return $signed(48'($urandom_range(0, 1 << 27))) - 48'sd67108864;
  endfunction

  function automatic logic signed [31:0] rnd_gain();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed(32'($urandom_range(0, 1 << 18))) - 32'sd131072;
  endfunction

  function automatic logic signed [63:0] rnd_acc();
    if ($urandom_range(0, 3) == 0) return rnd64();
    return $signed(64'($urandom)) - 64'sd2147483648;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OFF_X: off_x = val;
      CFG_OFF_Y: off_y = val;
      default: off_z = val;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sent_cnt != queued_cnt || expected_points.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  point_req_t cur;
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        apply_request(cur);
        sent_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          busy = 1'b1;
          in_opcode <= cur.op;
          in_table_index <= cur.tidx;
          in_table_value <= cur.tval;
          in_x_coord <= cur.x;
          in_y_coord <= cur.y;
          in_z_coord <= cur.z;
          in_gain <= cur.gain;
          in_acc_in <= cur.acc;
          in_sweep_last <= cur.sweep;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= busy;
    end
  end

  // Result monitor with its own stall pattern.
  int mon_cyc = 0;
  always @(posedge clk) begin
    point_res_t e;
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_cnt++;
        if (expected_points.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("ERROR: unexpected result noise=%0d acc=%0d",
                                      out_noise_value, out_acc_out);
        end else begin
          e = expected_points.pop_front();
          if (out_noise_value !== e.noise || out_acc_out !== e.acc ||
              out_sweep_end !== e.sweep) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ERROR: result %0d exp noise=%0d acc=%0d end=%0b got %0d %0d %0b",
                       checked_cnt, e.noise, e.acc, e.sweep, out_noise_value,
                       out_acc_out, out_sweep_end);
          end
        end
      end
      mon_cyc++;
      case ((mon_cyc / 300) % 4)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 9) < 7);
        2: rdy = (mon_cyc % 4 != 0);
        default: rdy = ($urandom_range(0, 9) < 3);
      endcase
      out_ready <= rdy;
    end
  end

  int idle_cyc = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cyc);
      $display("FAIL simplex_noise_2d_3d");
      $finish;
    end
  end

  initial begin
    logic [7:0] shuf[256];
    logic [7:0] tmp;
    int j, n, op_pick;
    logic [1:0] op;
    logic signed [47:0] bx, by, bz, sx, sy, sz;
    logic signed [31:0] g;
    off_x = '0;
    off_y = '0;
    off_z = '0;
    foreach (perm_tbl[k]) perm_tbl[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_OFF_X, 24'd0);
          write_reg(CFG_OFF_Y, 24'd0);
          write_reg(CFG_OFF_Z, 24'd0);
        end
        1: begin
          write_reg(CFG_OFF_X, 24'hFFFFFF);
          write_reg(CFG_OFF_Y, 24'hFFFFFF);
          write_reg(CFG_OFF_Z, 24'hFFFFFF);
        end
        default: begin
          write_reg(CFG_OFF_X, 24'($urandom));
          write_reg(CFG_OFF_Y, 24'($urandom));
          write_reg(CFG_OFF_Z, 24'($urandom));
        end
      endcase
      if (phase == 0) begin
        foreach (shuf[k]) shuf[k] = 8'(k);
        for (int k = 255; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = shuf[k];
          shuf[k] = shuf[j];
          shuf[j] = tmp;
        end
        for (int k = 0; k < 256; k++) begin
          queue_point(OP_LOAD, 0, 0, 0, 0, 0, 0);
          pending_reqs[$].tidx = 8'(k);
          pending_reqs[$].tval = shuf[k];
        end
        queue_point(OP_EVAL2, 0, 0, 0, 32'sh10000, 0, 1'b0);
        queue_point(OP_EVAL3, 0, 0, 0, 32'sh10000, 0, 1'b1);
        queue_point(OP_EVAL2, -48'sd196608, -48'sd327680, 0, 32'sh10000, 0, 1'b0);
        queue_point(OP_EVAL3, -48'sd65536, 48'sd131072, -48'sd262144, 32'sh10000, 0, 1'b0);
        queue_point(OP_EVAL3, 48'sd131072, 48'sd196608, 48'sd65536, 32'sh10000, 0, 1'b0);
        queue_point(OP_EVAL2, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 0,
                    32'sh7FFF_FFFF, S64_MAX, 1'b1);
        queue_point(OP_EVAL2, 48'sh8000_0000_0000, 48'sh8000_0000_0000, 0,
                    32'sh8000_0000, S64_MIN, 1'b0);
        queue_point(OP_EVAL3, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000,
                    48'sh7FFF_FFFF_FFFF, 32'sh7FFF_FFFF, S64_MIN, 1'b0);
        queue_point(OP_EVAL3, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
                    48'sh8000_0000_0000, 32'sh8000_0000, S64_MAX, 1'b1);
        for (int k = 0; k < 6; k++) begin
          op = k[0] ? OP_EVAL3 : OP_EVAL2;
          queue_point(op, 48'(k * 21845), 48'(k * 9000 - 20000), 48'(k * 33000),
                      k[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                      k[2] ? S64_MAX : S64_MIN, k[0]);
        end
        queue_point(OP_EVAL2, 48'sd40000, 48'sd70000, 0, 0, -64'sd12345, 1'b0);
        queue_point(OP_NONE, rnd48(), rnd48(), rnd48(), $urandom, rnd64(), 1'b1);
        queue_point(OP_EVAL3, 48'sd123456, -48'sd98765, 48'sd55555, 32'sh20000, 0, 1'b0);
      end
      n = 0;
      while (n < 220) begin
        op_pick = $urandom_range(0, 99);
        if (op_pick < 6) begin
          queue_point(OP_LOAD, 0, 0, 0, 0, 0, 0);
          n++;
        end else if (op_pick < 8) begin
          queue_point(OP_NONE, rnd48(), rnd48(), rnd48(), $urandom, rnd64(), 1'($urandom));
        end else if (op_pick < 25) begin
          queue_point(($urandom_range(0, 1) != 0) ? OP_EVAL3 : OP_EVAL2, rnd48(), rnd48(),
                      rnd48(), $urandom, rnd64(), 1'($urandom));
          n++;
        end else begin
          // A short grid sweep with a constant step and the end flag on its last point.
          op = ($urandom_range(0, 1) != 0) ? OP_EVAL3 : OP_EVAL2;
          bx = rnd_coord();
          by = rnd_coord();
          bz = rnd_coord();
          sx = 48'($urandom_range(0, 40000));
          sy = 48'($urandom_range(0, 40000));
          sz = 48'($urandom_range(0, 40000));
          g = rnd_gain();
          j = $urandom_range(4, 12);
          for (int k = 0; k < j; k++) begin
            queue_point(op, bx + k * sx, by + k * sy, bz + k * sz, g, rnd_acc(), k == j - 1);
          end
          n += j;
        end
      end
      wait_drained();
    end
    $display("Covered %0d table loads, %0d 2D and %0d 3D evaluations, %0d offset writes.",
             n_load, n_eval2, n_eval3, n_cfg);
    $display("Checked %0d results, %0d mismatches.", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS simplex_noise_2d_3d");
    end else begin
      $display("FAIL simplex_noise_2d_3d");
    end
    $finish;
  end

endmodule
